>>> rtl/macs_pkg.sv
// Shared constants, types and codes for the moving average crossover block.
`default_nettype none

package macs_pkg;

    // Ring depth; must be a power of two so the pointer wraps on its own.
    localparam int MAX_WINDOW = 256;
    localparam int PRICE_BITS = 32;
    localparam int CLOSE_BITS = 32;
    localparam int WIN_BITS   = 9;
    localparam int ADDR_BITS  = $clog2(MAX_WINDOW);
    // A sum of MAX_WINDOW prices always fits here.
    localparam int SUM_BITS   = PRICE_BITS + ADDR_BITS;
    localparam int PROD_BITS  = SUM_BITS + WIN_BITS;
    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;

    typedef logic [PRICE_BITS-1:0] price_t;
    typedef logic [CLOSE_BITS-1:0] close_t;
    typedef logic [SUM_BITS-1:0]   sum_t;
    typedef logic [PROD_BITS-1:0]  prod_t;
    typedef logic [WIN_BITS-1:0]   win_t;
    typedef logic [ADDR_BITS-1:0]  addr_t;
    typedef logic signed [1:0]     signal_t;

    localparam signal_t SIG_NONE = 2'sd0;
    localparam signal_t SIG_BUY  = 2'sd1;
    localparam signal_t SIG_SELL = -2'sd1;

    // Register index, taken from paddr[2].
    localparam logic REG_SHORT = 1'b0;
    localparam logic REG_LONG  = 1'b1;

    localparam win_t SHORT_RESET = 9'd20;
    localparam win_t LONG_RESET  = 9'd50;

    typedef struct packed {
        logic warm;
        logic sub_short;
        logic sub_long;
    } s1_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/macs_price_if.sv
// Stream interface that carries one closing price per transaction.
`default_nettype none

interface macs_price_if;
    logic             valid;
    logic             ready;
    macs_pkg::close_t close_price;

    modport source (output valid, output close_price, input ready);
    modport sink   (input valid, input close_price, output ready);
endinterface

`default_nettype wire

>>> rtl/macs_signal_if.sv
// Stream interface that carries one trade signal per transaction.
`default_nettype none

interface macs_signal_if;
    logic              valid;
    logic              ready;
    macs_pkg::signal_t trade_signal;
    logic              warmed_up;

    modport source (output valid, output trade_signal, output warmed_up, input ready);
    modport sink   (input valid, input trade_signal, input warmed_up, output ready);
endinterface

`default_nettype wire

>>> rtl/macs_ram.sv
// Generic RAM: one write port, two registered read ports, old data on collision.
`default_nettype none

module macs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

>>> rtl/moving_average_crossover_signal.sv
// Each price passes through the read stage and then the result register before its result is valid.
// Throughput: one price per cycle; the ring is written and both window tails read at accept.
// The running sums update as each result is registered; prices stall only while a result is held.
// Reset: windows return to 20 and 50; sums, pointer, price count and last signal clear.
// A register write restarts the stream the same way; ring contents are kept but not read.
`default_nettype none

module moving_average_crossover_signal (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    macs_price_if.sink                               price_in,
    macs_signal_if.source                            signal_out,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [macs_pkg::PADDR_BITS-1:0]     paddr,
    input  wire logic [macs_pkg::PDATA_BITS-1:0]     pwdata,
    output logic      [macs_pkg::PDATA_BITS-1:0]     prdata,
    output logic                                     pready
);

    // Configuration
    macs_pkg::win_t short_cfg_reg;
    macs_pkg::win_t long_cfg_reg;
    macs_pkg::win_t eff_long;
    macs_pkg::win_t eff_short;
    logic           cfg_write;

    // Accept side
    macs_pkg::addr_t    wp_reg;
    macs_pkg::addr_t    wp_next;
    macs_pkg::win_t     seen_reg;
    macs_pkg::win_t     seen_next;
    macs_pkg::addr_t    raddr_short;
    macs_pkg::addr_t    raddr_long;
    macs_pkg::price_t   in_price;
    logic               in_fire;

    // Read stage
    logic               s1_valid_reg;
    logic               s1_valid_next;
    macs_pkg::price_t   s1_price_reg;
    macs_pkg::s1_ctrl_t s1_ctrl_reg;
    macs_pkg::s1_ctrl_t s1_ctrl_in;
    macs_pkg::price_t   rd_short;
    macs_pkg::price_t   rd_long;
    logic               s1_move;

    // Sums and decision
    macs_pkg::sum_t     short_sum_reg;
    macs_pkg::sum_t     short_sum_next;
    macs_pkg::sum_t     long_sum_reg;
    macs_pkg::sum_t     long_sum_next;
    macs_pkg::prod_t    short_prod;
    macs_pkg::prod_t    long_prod;
    macs_pkg::signal_t  last_signal_reg;
    macs_pkg::signal_t  sig_next;

    // Result register
    logic               out_valid_reg;
    logic               out_valid_next;
    macs_pkg::signal_t  out_signal_reg;
    logic               out_warm_reg;

    // ---------------------------------------------------------------- APB
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_cfg_reg <= macs_pkg::SHORT_RESET;
            long_cfg_reg  <= macs_pkg::LONG_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                macs_pkg::REG_SHORT: short_cfg_reg <= pwdata[macs_pkg::WIN_BITS-1:0];
                default:             long_cfg_reg  <= pwdata[macs_pkg::WIN_BITS-1:0];
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            macs_pkg::REG_SHORT: prdata = macs_pkg::PDATA_BITS'(short_cfg_reg);
            default:             prdata = macs_pkg::PDATA_BITS'(long_cfg_reg);
        endcase
    end

    // Clamp the windows: zero acts as one, long to the ring depth, short to long.
    always_comb
    begin
        if (long_cfg_reg == '0)
            eff_long = macs_pkg::win_t'(1);
        else if (32'(long_cfg_reg) > macs_pkg::MAX_WINDOW)
            eff_long = macs_pkg::win_t'(macs_pkg::MAX_WINDOW);
        else
            eff_long = long_cfg_reg;

        if (short_cfg_reg == '0)
            eff_short = macs_pkg::win_t'(1);
        else if (short_cfg_reg > eff_long)
            eff_short = eff_long;
        else
            eff_short = short_cfg_reg;
    end

    // ------------------------------------------------------------- accept
    assign s1_move        = s1_valid_reg && (!out_valid_reg || signal_out.ready);
    assign price_in.ready = !s1_valid_reg || s1_move;
    assign in_fire        = price_in.valid && price_in.ready;

    assign in_price = macs_pkg::price_t'({{macs_pkg::PRICE_BITS{1'b0}}, price_in.close_price});

    // Tail entries leaving each window; a full-depth window reads the slot
    // being overwritten, which the RAM returns as old data.
    assign raddr_short = wp_reg
        - macs_pkg::addr_t'({{macs_pkg::ADDR_BITS{1'b0}}, eff_short});
    assign raddr_long  = wp_reg
        - macs_pkg::addr_t'({{macs_pkg::ADDR_BITS{1'b0}}, eff_long});

    assign s1_ctrl_in.warm      = (seen_reg >= eff_long);
    assign s1_ctrl_in.sub_long  = (seen_reg >= eff_long);
    assign s1_ctrl_in.sub_short = (seen_reg >= eff_short);

    assign wp_next   = wp_reg + macs_pkg::addr_t'(1);
    assign seen_next = (seen_reg < eff_long) ? seen_reg + macs_pkg::win_t'(1) : seen_reg;

    macs_ram #(
        .WIDTH (macs_pkg::PRICE_BITS),
        .DEPTH (macs_pkg::MAX_WINDOW)
    ) u_history (
        .clk     (clk),
        .we      (in_fire),
        .waddr   (wp_reg),
        .wdata   (in_price),
        .re      (in_fire),
        .raddr_a (raddr_short),
        .raddr_b (raddr_long),
        .rdata_a (rd_short),
        .rdata_b (rd_long)
    );

    always_comb
    begin
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (s1_move)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            seen_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (cfg_write)
            begin
                wp_reg   <= '0;
                seen_reg <= '0;
            end
            else if (in_fire)
            begin
                wp_reg   <= wp_next;
                seen_reg <= seen_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_price_reg <= in_price;
            s1_ctrl_reg  <= s1_ctrl_in;
        end
    end

    // ----------------------------------------------------- sums, decision
    assign short_prod = macs_pkg::prod_t'(short_sum_reg) * macs_pkg::prod_t'(eff_long);
    assign long_prod  = macs_pkg::prod_t'(long_sum_reg) * macs_pkg::prod_t'(eff_short);

    always_comb
    begin
        sig_next = macs_pkg::SIG_NONE;
        if (s1_ctrl_reg.warm)
        begin
            if (short_prod > long_prod && last_signal_reg != macs_pkg::SIG_BUY)
                sig_next = macs_pkg::SIG_BUY;
            else if (short_prod < long_prod && last_signal_reg != macs_pkg::SIG_SELL)
                sig_next = macs_pkg::SIG_SELL;
        end
    end

    // Drop the tails leaving each window, then add the new price.
    assign short_sum_next = short_sum_reg
        - (s1_ctrl_reg.sub_short ? macs_pkg::sum_t'(rd_short) : '0)
        + macs_pkg::sum_t'(s1_price_reg);
    assign long_sum_next  = long_sum_reg
        - (s1_ctrl_reg.sub_long ? macs_pkg::sum_t'(rd_long) : '0)
        + macs_pkg::sum_t'(s1_price_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_sum_reg   <= '0;
            long_sum_reg    <= '0;
            last_signal_reg <= macs_pkg::SIG_NONE;
        end
        else if (cfg_write)
        begin
            short_sum_reg   <= '0;
            long_sum_reg    <= '0;
            last_signal_reg <= macs_pkg::SIG_NONE;
        end
        else if (s1_move)
        begin
            short_sum_reg <= short_sum_next;
            long_sum_reg  <= long_sum_next;
            if (sig_next != macs_pkg::SIG_NONE)
                last_signal_reg <= sig_next;
        end
    end

    // ------------------------------------------------------ result output
    always_comb
    begin
        if (s1_move)
            out_valid_next = 1'b1;
        else if (signal_out.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_signal_reg <= sig_next;
            out_warm_reg   <= s1_ctrl_reg.warm;
        end
    end

    assign signal_out.valid        = out_valid_reg;
    assign signal_out.trade_signal = out_signal_reg;
    assign signal_out.warmed_up    = out_warm_reg;

    // ---------------------------------------------------------- assertions
    a_legal_code: assert property (@(posedge clk) disable iff (!rst_n)
        signal_out.valid |->
            (signal_out.trade_signal == macs_pkg::SIG_NONE ||
             signal_out.trade_signal == macs_pkg::SIG_BUY ||
             signal_out.trade_signal == macs_pkg::SIG_SELL))
        else $error("illegal trade signal code");

    a_cold_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (signal_out.valid && !signal_out.warmed_up) |->
            signal_out.trade_signal == macs_pkg::SIG_NONE)
        else $error("signal emitted before warm-up");

    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= eff_long)
        else $error("price count beyond long window");

    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && sig_next != macs_pkg::SIG_NONE) |-> sig_next != last_signal_reg)
        else $error("same signal emitted twice in a row");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |=> (s1_valid_reg && $stable(s1_price_reg)))
        else $error("stalled price lost from read stage");

endmodule

`default_nettype wire

>>> dv/tb_moving_average_crossover_signal.sv
// Testbench for the moving average crossover block: directed table, random price trends, scoreboard.
`default_nettype none

module tb_moving_average_crossover_signal;

    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;

    typedef struct packed {
        macs_pkg::signal_t trade;
        logic              warm;
    } verdict_t;

    typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_CONFIG} row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic              reg_idx;
        logic [31:0]       value;
        macs_pkg::signal_t trade;
        logic              warm;
    } stim_row_t;

    typedef struct packed {
        macs_pkg::win_t short_len;
        macs_pkg::win_t long_len;
        int             items;
    } window_phase_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [macs_pkg::PADDR_BITS-1:0] paddr;
    logic [macs_pkg::PDATA_BITS-1:0] pwdata;
    logic [macs_pkg::PDATA_BITS-1:0] prdata;
    logic pready;

    macs_price_if  price_if ();
    macs_signal_if sig_if ();

    moving_average_crossover_signal DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .price_in   (price_if),
        .signal_out (sig_if),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Crossover predictor state
    macs_pkg::close_t   ring_prices [macs_pkg::MAX_WINDOW];
    macs_pkg::sum_t     fast_sum;
    macs_pkg::sum_t     slow_sum;
    macs_pkg::addr_t    ring_head;
    macs_pkg::win_t     fill_count;
    macs_pkg::signal_t  last_nonzero;
    macs_pkg::win_t     cfg_short;
    macs_pkg::win_t     cfg_long;

    verdict_t           pending_verdicts [$];
    int                 errors;
    int                 prices_taken;
    int                 burst_left;
    int                 quiet_cycles;
    macs_pkg::close_t   trend_level;
    longint             trend_step;

    stim_row_t directed_rows [21] = '{
        '{ROW_TYPED,   macs_pkg::REG_SHORT, 32'h0000_0000, macs_pkg::SIG_NONE, 1'b0},
        '{ROW_TYPED,   macs_pkg::REG_SHORT, 32'hFFFF_FFFF, macs_pkg::SIG_NONE, 1'b0},
        // zero windows behave as one; upper data bits are dropped
        '{ROW_CONFIG,  macs_pkg::REG_SHORT, 32'h8000_0000, macs_pkg::SIG_NONE, 1'b0},
        '{ROW_CONFIG,  macs_pkg::REG_LONG,  32'h0000_0000, macs_pkg::SIG_NONE, 1'b0},
        '{ROW_TYPED,   macs_pkg::REG_SHORT, 32'hFFFF_FFFF, macs_pkg::SIG_NONE, 1'b0},
        // equal means give no action
        '{ROW_TYPED,   macs_pkg::REG_SHORT, 32'h0000_0005, macs_pkg::SIG_NONE, 1'b1},
        '{ROW_CONFIG,  macs_pkg::REG_LONG,  32'h0000_0002, macs_pkg::SIG_NONE, 1'b0},
        '{ROW_CONFIG,  macs_pkg::REG_SHORT, 32'h0000_0001, macs_pkg::SIG_NONE, 1'b0},
        '{ROW_TYPED,   macs_pkg::REG_SHORT, 32'd10,        macs_pkg::SIG_NONE, 1'b0},
        '{ROW_TYPED,   macs_pkg::REG_SHORT, 32'd20,        macs_pkg::SIG_NONE, 1'b0},
        // buy, sell, equal, buy, repeated buy suppressed twice, sell
        '{ROW_PREDICT, macs_pkg::REG_SHORT, 32'd0,         macs_pkg::SIG_NONE, 1'b0},
        '{ROW_PREDICT, macs_pkg::REG_SHORT, 32'd0,         macs_pkg::SIG_NONE, 1'b0},
        '{ROW_PREDICT, macs_pkg::REG_SHORT, 32'd7,         macs_pkg::SIG_NONE, 1'b0},
        '{ROW_PREDICT, macs_pkg::REG_SHORT, 32'd100,       macs_pkg::SIG_NONE, 1'b0},
        '{ROW_PREDICT, macs_pkg::REG_SHORT, 32'd200,       macs_pkg::SIG_NONE, 1'b0},
        '{ROW_PREDICT, macs_pkg::REG_SHORT, 32'd0,         macs_pkg::SIG_NONE, 1'b0},
        '{ROW_PREDICT, macs_pkg::REG_SHORT, 32'd5,         macs_pkg::SIG_NONE, 1'b0},
        // long window saturates at the ring depth, short window at the long one
        '{ROW_CONFIG,  macs_pkg::REG_LONG,  32'h0000_01FF, macs_pkg::SIG_NONE, 1'b0},
        '{ROW_CONFIG,  macs_pkg::REG_SHORT, 32'h0000_012C, macs_pkg::SIG_NONE, 1'b0},
        '{ROW_TYPED,   macs_pkg::REG_SHORT, 32'hFFFF_FFFF, macs_pkg::SIG_NONE, 1'b0},
        '{ROW_TYPED,   macs_pkg::REG_SHORT, 32'h0000_0000, macs_pkg::SIG_NONE, 1'b0}
    };

    window_phase_t window_phases [6] = '{
        '{9'd3,   9'd8,   120},
        '{9'd1,   9'd1,   60},
        '{9'd5,   9'd5,   40},
        '{9'd16,  9'd511, 330},
        '{9'd511, 9'd40,  50},
        '{9'd7,   9'd13,  50}
    };

    function automatic void restart_stream();
        fast_sum     = '0;
        slow_sum     = '0;
        ring_head    = '0;
        fill_count   = '0;
        last_nonzero = macs_pkg::SIG_NONE;
    endfunction

    // Append one expectation at the tail of the scoreboard queue
    function automatic void queue_verdict(verdict_t v);
        pending_verdicts = {pending_verdicts, v};
    endfunction

    function automatic verdict_t predict_crossover(macs_pkg::close_t price);
        int              l;
        int              s;
        longint unsigned lhs;
        longint unsigned rhs;
        verdict_t        v;
        if (cfg_long == 0)
            l = 1;
        else if (int'(cfg_long) > macs_pkg::MAX_WINDOW)
            l = macs_pkg::MAX_WINDOW;
        else
            l = int'(cfg_long);
        s = (cfg_short == 0) ? 1 : int'(cfg_short);
        if (s > l)
            s = l;
        v.trade = macs_pkg::SIG_NONE;
        v.warm  = 1'b0;
        if (int'(fill_count) >= l)
        begin
            v.warm = 1'b1;
            lhs = longint'(fast_sum) * longint'(l);
            rhs = longint'(slow_sum) * longint'(s);
            if (lhs > rhs && last_nonzero != macs_pkg::SIG_BUY)
                v.trade = macs_pkg::SIG_BUY;
            else if (lhs < rhs && last_nonzero != macs_pkg::SIG_SELL)
                v.trade = macs_pkg::SIG_SELL;
            if (v.trade != macs_pkg::SIG_NONE)
                last_nonzero = v.trade;
        end
        // drop the prices leaving each window, then push the new one
        if (int'(fill_count) >= s)
            fast_sum -= ring_prices[(int'(ring_head) + macs_pkg::MAX_WINDOW - s)
                                    % macs_pkg::MAX_WINDOW];
        if (int'(fill_count) >= l)
            slow_sum -= ring_prices[(int'(ring_head) + macs_pkg::MAX_WINDOW - l)
                                    % macs_pkg::MAX_WINDOW];
        fast_sum += price;
        slow_sum += price;
        ring_prices[ring_head] = price;
        ring_head++;
        if (int'(fill_count) < l)
            fill_count++;
        return v;
    endfunction

    // Trending prices with reversals, plus some raw and extreme values
    function automatic macs_pkg::close_t next_close();
        int     pick;
        longint level;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return macs_pkg::close_t'($urandom());
        if (pick < 8)
            return pick[0] ? '1 : '0;
        if ($urandom_range(0, 24) == 0)
            trend_step = -trend_step;
        if ($urandom_range(0, 29) == 0)
            trend_step = longint'($urandom_range(0, 4000)) - 2000;
        level = longint'(trend_level) + trend_step + longint'($urandom_range(0, 2000)) - 1000;
        if (level < 0)
            level = 0;
        if (level > longint'(32'hFFFF_FFFF))
            level = longint'(32'hFFFF_FFFF);
        trend_level = macs_pkg::close_t'(level);
        return trend_level;
    endfunction

    task automatic push_price(macs_pkg::close_t price, logic typed, verdict_t typed_v);
        int       gap;
        verdict_t predicted;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                price_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        price_if.valid       <= 1'b1;
        price_if.close_price <= price;
        do
            @(posedge clk);
        while (price_if.ready !== 1'b1);
        prices_taken++;
        predicted = predict_crossover(price);
        queue_verdict(typed ? typed_v : predicted);
    endtask

    // Drop valid and wait until every expected signal has come back
    task automatic settle();
        price_if.valid <= 1'b0;
        burst_left = 0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_window(logic idx, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if (idx == macs_pkg::REG_SHORT)
            cfg_short = data[macs_pkg::WIN_BITS-1:0];
        else
            cfg_long = data[macs_pkg::WIN_BITS-1:0];
        restart_stream();
        // read back in a second transaction, psel held
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if (prdata[macs_pkg::WIN_BITS-1:0] !== data[macs_pkg::WIN_BITS-1:0])
        begin
            $error("window register %0d: expected %0d, got %0d", idx,
                   data[macs_pkg::WIN_BITS-1:0], prdata[macs_pkg::WIN_BITS-1:0]);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        // leave the bus idle before the next transaction
        @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n                <= 1'b0;
        price_if.valid       <= 1'b0;
        price_if.close_price <= '0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        errors       = 0;
        prices_taken = 0;
        burst_left   = 0;
        trend_level  = macs_pkg::close_t'($urandom());
        trend_step   = 500;
        cfg_short    = macs_pkg::SHORT_RESET;
        cfg_long     = macs_pkg::LONG_RESET;
        foreach (ring_prices[i])
            ring_prices[i] = '0;
        restart_stream();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CONFIG)
            begin
                settle();
                set_window(directed_rows[i].reg_idx, directed_rows[i].value);
            end
            else
            begin
                push_price(directed_rows[i].value, directed_rows[i].kind == ROW_TYPED,
                           '{trade: directed_rows[i].trade, warm: directed_rows[i].warm});
            end
        end

        foreach (window_phases[i])
        begin
            settle();
            set_window(macs_pkg::REG_SHORT,
                       ($urandom_range(0, 1) ? ($urandom() & 32'hFFFF_FE00) : 32'h0)
                       | 32'(window_phases[i].short_len));
            set_window(macs_pkg::REG_LONG,
                       ($urandom_range(0, 1) ? ($urandom() & 32'hFFFF_FE00) : 32'h0)
                       | 32'(window_phases[i].long_len));
            repeat (window_phases[i].items)
                push_price(next_close(), 1'b0, '0);
        end

        settle();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("tb_moving_average_crossover_signal: done, clean");
        else
            $display("tb_moving_average_crossover_signal: done, errors");
        $finish;
    end

    // Receiver: stall patterns that change now and then, and one long hold-off
    initial
    begin
        int   mode;
        int   left;
        int   cycle;
        logic long_hold_done;
        sig_if.ready <= 1'b0;
        mode           = 0;
        left           = 0;
        cycle          = 0;
        long_hold_done = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            cycle++;
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 120);
            end
            left--;
            if (!long_hold_done && prices_taken >= 60)
            begin
                long_hold_done = 1'b1;
                sig_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                case (mode)
                    0:       sig_if.ready <= 1'b1;
                    1:       sig_if.ready <= ($urandom_range(0, 1) == 0);
                    2:       sig_if.ready <= (cycle % 3 != 0);
                    default: sig_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Compare each signal transaction with the oldest expectation
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && sig_if.valid === 1'b1 && sig_if.ready === 1'b1)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("trade_signal: expected nothing, got %0d", sig_if.trade_signal);
                errors++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (sig_if.trade_signal !== want.trade)
                begin
                    $error("trade_signal: expected %0d, got %0d", want.trade,
                           sig_if.trade_signal);
                    errors++;
                end
                if (sig_if.warmed_up !== want.warm)
                begin
                    $error("warmed_up: expected %0d, got %0d", want.warm, sig_if.warmed_up);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((price_if.valid === 1'b1 && price_if.ready === 1'b1)
            || (sig_if.valid === 1'b1 && sig_if.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb_moving_average_crossover_signal: done, errors");
            $finish;
        end
    end

    initial
        quiet_cycles = 0;

endmodule

`default_nettype wire

>>> files.f
rtl/macs_pkg.sv
rtl/macs_price_if.sv
rtl/macs_signal_if.sv
rtl/macs_ram.sv
rtl/moving_average_crossover_signal.sv
dv/tb_moving_average_crossover_signal.sv
